### rtl/vbrc_pkg.sv
// vbrc_pkg: shared types and codes of the virtio block request checker
// no dependencies; used by the interfaces and every module under rtl
`timescale 1ns / 1ps

package vbrc_pkg;

    localparam int unsigned LEN_W    = 32;
    localparam int unsigned TYPE_W   = 32;
    localparam int unsigned SECTOR_W = 64;
    localparam int unsigned OUTC_W   = 3;
    localparam int unsigned BUFCNT_W = 8;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READ_ONLY = 1'd1;

    // header request types
    localparam logic [TYPE_W-1:0] TYPE_IN    = 32'd0;
    localparam logic [TYPE_W-1:0] TYPE_OUT   = 32'd1;
    localparam logic [TYPE_W-1:0] TYPE_GETID = 32'd8;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_GETID   = 2'd2,
        KIND_UNKNOWN = 2'd3
    } t_kind;

    typedef enum logic [OUTC_W-1:0] {
        OUT_READ   = 3'd0,
        OUT_WRITE  = 3'd1,
        OUT_GETID  = 3'd2,
        OUT_FAIL   = 3'd3,
        OUT_ABORT  = 3'd4,
        OUT_IGNORE = 3'd5
    } t_outcome;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef struct packed {
        logic [LEN_W-1:0]    desc_len;
        logic                desc_write_only;
        logic                desc_last;
        logic [TYPE_W-1:0]   hdr_type;
        logic [SECTOR_W-1:0] hdr_sector;
    } t_word;

    typedef struct packed {
        logic [OUTC_W-1:0]   outcome;
        logic [SECTOR_W-1:0] first_sector_out;
        logic [SECTOR_W-1:0] sector_count;
        logic [BUFCNT_W-1:0] data_buffer_count;
    } t_result;

endpackage

### rtl/vbrc_desc_if.sv
// vbrc_desc_if: valid/ready channel carrying one descriptor word
// depends on vbrc_pkg for field widths
`timescale 1ns / 1ps

interface vbrc_desc_if;
    import vbrc_pkg::*;

    logic                valid;
    logic                ready;
    logic [LEN_W-1:0]    desc_len;
    logic                desc_write_only;
    logic                desc_last;
    logic [TYPE_W-1:0]   hdr_type;
    logic [SECTOR_W-1:0] hdr_sector;

    modport source (
        output valid, desc_len, desc_write_only, desc_last, hdr_type, hdr_sector,
        input  ready
    );
    modport sink (
        input  valid, desc_len, desc_write_only, desc_last, hdr_type, hdr_sector,
        output ready
    );
endinterface

### rtl/vbrc_res_if.sv
// vbrc_res_if: valid/ready channel carrying one request outcome word
// depends on vbrc_pkg for field widths
`timescale 1ns / 1ps

interface vbrc_res_if;
    import vbrc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUTC_W-1:0]   outcome;
    logic [SECTOR_W-1:0] first_sector_out;
    logic [SECTOR_W-1:0] sector_count;
    logic [BUFCNT_W-1:0] data_buffer_count;

    modport source (
        output valid, outcome, first_sector_out, sector_count, data_buffer_count,
        input  ready
    );
    modport sink (
        input  valid, outcome, first_sector_out, sector_count, data_buffer_count,
        output ready
    );
endinterface

### rtl/vbrc_front.sv
// vbrc_front: input register and sector quotient of the descriptor length
// depends on vbrc_pkg and vbrc_desc_if; feeds vbrc_chain
`timescale 1ns / 1ps

module vbrc_front #(
    parameter int unsigned SECTOR_BYTES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    vbrc_desc_if.sink            i_desc,
    output logic                 o_mid_valid,
    input  logic                 i_mid_ready,
    output vbrc_pkg::t_word      o_mid,
    output logic [32-$clog2(SECTOR_BYTES):0] o_quot
);
    import vbrc_pkg::*;

    localparam int unsigned SEC_L  = $clog2(SECTOR_BYTES);
    localparam int unsigned Q_W    = 33 - SEC_L;
    localparam int unsigned DIV_SH = LEN_W + SEC_L;
    localparam logic [63:0] DIV_NUM = (64'd1 << DIV_SH) + 64'(SECTOR_BYTES) - 64'd1;
    localparam logic [LEN_W:0] DIV_MUL = (LEN_W + 1)'(DIV_NUM / 64'(SECTOR_BYTES));
    localparam int unsigned PROD_W = 2 * LEN_W + 1;

    logic            r_in_valid;
    t_word           r_in;
    logic            r_mid_valid;
    t_word           r_mid;
    logic [Q_W-1:0]  r_quot;
    logic            w_move;
    logic [PROD_W-1:0] w_prod;

    // quotient by reciprocal multiply, exact for every 32-bit length
    assign w_prod = PROD_W'(r_in.desc_len) * PROD_W'(DIV_MUL);
    assign w_move = !r_mid_valid || i_mid_ready;
    assign i_desc.ready = !r_in_valid || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
        end else begin
            if (i_desc.ready) begin
                r_in_valid <= i_desc.valid;
            end
            if (w_move) begin
                r_mid_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_desc.valid && i_desc.ready) begin
            r_in.desc_len        <= i_desc.desc_len;
            r_in.desc_write_only <= i_desc.desc_write_only;
            r_in.desc_last       <= i_desc.desc_last;
            r_in.hdr_type        <= i_desc.hdr_type;
            r_in.hdr_sector      <= i_desc.hdr_sector;
        end
        if (w_move && r_in_valid) begin
            r_mid  <= r_in;
            r_quot <= w_prod[DIV_SH +: Q_W];
        end
    end

    assign o_mid_valid = r_mid_valid;
    assign o_mid       = r_mid;
    assign o_quot      = r_quot;

endmodule

### rtl/vbrc_chain.sv
// vbrc_chain: per-chain state, sector sum, outcome decision and result register
// depends on vbrc_pkg and vbrc_res_if; fed by vbrc_front
`timescale 1ns / 1ps

module vbrc_chain #(
    parameter int unsigned MAX_DESCRIPTORS = 128,
    parameter int unsigned HEADER_BYTES    = 16,
    parameter int unsigned SECTOR_BYTES    = 512,
    parameter int unsigned ID_BYTES        = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vbrc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vbrc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_mid_valid,
    output logic                              o_mid_ready,
    input  vbrc_pkg::t_word                   i_mid,
    input  logic [32-$clog2(SECTOR_BYTES):0]  i_quot,
    vbrc_res_if.source                        o_res
);
    import vbrc_pkg::*;

    logic [SECTOR_W-1:0] r_capacity;
    logic                r_read_only;

    logic [POS_W-1:0]    r_pos;
    logic                r_hdr_bad;
    t_kind               r_kind;
    logic [SECTOR_W-1:0] r_saved;
    logic [SECTOR_W-1:0] r_sum;
    logic                r_fault;

    logic                r_out_valid;
    t_result             r_out;

    logic                w_take;
    logic                w_first;
    logic [POS_W-1:0]    n_pos;
    logic                n_hdr_bad;
    t_kind               w_type_kind;
    t_kind               w_kind;
    logic [SECTOR_W-1:0] w_saved;
    logic [SECTOR_W-1:0] w_sum;
    logic                w_fault;
    logic                w_status_ok;
    logic                w_rem_ok;
    logic [LEN_W-1:0]    w_back;
    logic [SECTOR_W:0]   w_add;
    logic [SECTOR_W-1:0] w_sum_sat;
    logic                w_dir_bad;
    logic [SECTOR_W-1:0] w_last_sec;
    t_outcome            w_outcome;
    logic                w_dispatch;

    assign o_mid_ready = !i_mid.desc_last || !r_out_valid || o_res.ready;
    assign w_take      = i_mid_valid && o_mid_ready;
    assign w_first     = (r_pos == '0);
    assign n_pos       = (r_pos == POS_MAX) ? POS_MAX : r_pos + POS_W'(1);

    always_comb begin
        unique case (i_mid.hdr_type)
            TYPE_IN:    w_type_kind = KIND_READ;
            TYPE_OUT:   w_type_kind = KIND_WRITE;
            TYPE_GETID: w_type_kind = KIND_GETID;
            default:    w_type_kind = KIND_UNKNOWN;
        endcase
    end

    assign n_hdr_bad = i_mid.desc_write_only || (i_mid.desc_len != LEN_W'(HEADER_BYTES));
    assign w_kind    = w_first ? w_type_kind : r_kind;
    assign w_saved   = w_first ? i_mid.hdr_sector : r_saved;
    assign w_sum     = w_first ? '0 : r_sum;
    assign w_fault   = w_first ? 1'b0 : r_fault;

    // data buffer checks
    assign w_back    = LEN_W'(i_quot) * LEN_W'(SECTOR_BYTES);
    assign w_rem_ok  = (w_back == i_mid.desc_len);
    assign w_add     = {1'b0, r_sum} + (SECTOR_W + 1)'(i_quot);
    assign w_sum_sat = w_add[SECTOR_W] ? '1 : w_add[SECTOR_W-1:0];
    assign w_dir_bad = ((r_kind == KIND_READ) && !i_mid.desc_write_only)
                    || ((r_kind == KIND_WRITE) && i_mid.desc_write_only);

    assign w_status_ok = (i_mid.desc_len == LEN_W'(1)) && i_mid.desc_write_only;
    assign w_last_sec  = w_saved + w_sum - SECTOR_W'(1);

    always_comb begin
        priority if ((w_first ? n_hdr_bad : r_hdr_bad)) begin
            w_outcome = OUT_ABORT;
        end else if (32'(n_pos) > 32'(MAX_DESCRIPTORS)) begin
            w_outcome = OUT_ABORT;
        end else if (w_kind == KIND_UNKNOWN) begin
            w_outcome = OUT_IGNORE;
        end else if (w_kind == KIND_GETID) begin
            if (n_pos != POS_W'(3) || !w_status_ok) begin
                w_outcome = OUT_ABORT;
            end else begin
                w_outcome = w_fault ? OUT_FAIL : OUT_GETID;
            end
        end else if (n_pos < POS_W'(3) || !w_status_ok) begin
            w_outcome = OUT_ABORT;
        end else if (w_fault || w_sum == '0) begin
            w_outcome = OUT_FAIL;
        end else if (w_last_sec < w_saved || w_last_sec >= r_capacity) begin
            w_outcome = OUT_FAIL;
        end else if (w_kind == KIND_WRITE && r_read_only) begin
            w_outcome = OUT_FAIL;
        end else begin
            w_outcome = (w_kind == KIND_READ) ? OUT_READ : OUT_WRITE;
        end
    end

    assign w_dispatch = (w_outcome == OUT_READ) || (w_outcome == OUT_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= '0;
            r_read_only <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAPACITY:  r_capacity  <= i_cfg_data;
                REG_READ_ONLY: r_read_only <= i_cfg_data[0];
                default:       r_capacity  <= r_capacity;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_hdr_bad   <= 1'b0;
            r_kind      <= KIND_READ;
            r_saved     <= '0;
            r_sum       <= '0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_pos <= i_mid.desc_last ? '0 : n_pos;
                if (w_first) begin
                    r_hdr_bad <= n_hdr_bad;
                    r_kind    <= w_type_kind;
                    r_saved   <= i_mid.hdr_sector;
                    r_sum     <= '0;
                    r_fault   <= 1'b0;
                end else if (!i_mid.desc_last) begin
                    if (r_kind == KIND_READ || r_kind == KIND_WRITE) begin
                        r_sum <= w_sum_sat;
                        if (!w_rem_ok || w_dir_bad) begin
                            r_fault <= 1'b1;
                        end
                    end else if (r_kind == KIND_GETID && r_pos == POS_W'(1)) begin
                        if (i_mid.desc_len != LEN_W'(ID_BYTES) || !i_mid.desc_write_only) begin
                            r_fault <= 1'b1;
                        end
                    end
                end
            end
            if (w_take && i_mid.desc_last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_mid.desc_last) begin
            r_out.outcome           <= w_outcome;
            r_out.first_sector_out  <= w_dispatch ? w_saved : '0;
            r_out.sector_count      <= w_dispatch ? w_sum : '0;
            r_out.data_buffer_count <= w_dispatch ? BUFCNT_W'(n_pos - POS_W'(2)) : '0;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.outcome           = r_out.outcome;
    assign o_res.first_sector_out  = r_out.first_sector_out;
    assign o_res.sector_count      = r_out.sector_count;
    assign o_res.data_buffer_count = r_out.data_buffer_count;

endmodule

### rtl/virtio_blk_request_checker.sv
// Checks virtio block request chains one descriptor word per clock unless a held
// result stalls a last descriptor: the first word is the header, the last the
// status buffer, everything between is data. One outcome word is produced per
// chain after its last descriptor passes the input, middle and result registers;
// the rate is set by one pass through the quotient multiplier and 64-bit sum adder.
// Configuration (capacity, read-only) must be written only while no chain is
// in flight.
// Top level: vbrc_front feeding vbrc_chain; depends on vbrc_pkg and the interfaces
`timescale 1ns / 1ps

module virtio_blk_request_checker #(
    parameter int unsigned MAX_DESCRIPTORS = 128,
    parameter int unsigned HEADER_BYTES    = 16,
    parameter int unsigned SECTOR_BYTES    = 512,
    parameter int unsigned ID_BYTES        = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vbrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vbrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    vbrc_desc_if.sink                       i_desc,
    vbrc_res_if.source                      o_res
);
    import vbrc_pkg::*;

    localparam int unsigned Q_W = 33 - $clog2(SECTOR_BYTES);

    logic           w_mid_valid;
    logic           w_mid_ready;
    t_word          w_mid;
    logic [Q_W-1:0] w_quot;

    vbrc_front #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (i_desc),
        .o_mid_valid (w_mid_valid),
        .i_mid_ready (w_mid_ready),
        .o_mid       (w_mid),
        .o_quot      (w_quot)
    );

    vbrc_chain #(
        .MAX_DESCRIPTORS (MAX_DESCRIPTORS),
        .HEADER_BYTES    (HEADER_BYTES),
        .SECTOR_BYTES    (SECTOR_BYTES),
        .ID_BYTES        (ID_BYTES)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_mid_valid (w_mid_valid),
        .o_mid_ready (w_mid_ready),
        .i_mid       (w_mid),
        .i_quot      (w_quot),
        .o_res       (o_res)
    );

endmodule
